>>> hdl/near_duplicate_vector_counter_assert.svh
// Assertion macros for the checker file of the vector counter.
`ifndef NEAR_DUPLICATE_VECTOR_COUNTER_ASSERT_SVH
`define NEAR_DUPLICATE_VECTOR_COUNTER_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define NDVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define NDVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/ndvc_pkg.sv
`default_nettype none

package ndvc_pkg;

    // Default sizes of the vector store.
    localparam int MAX_ENTRIES_DEF = 1024;
    localparam int MAX_WIDTH_DEF   = 64;

    // Fixed field widths.
    localparam int ELEM_W = 16;
    localparam int THR_W  = 36;
    localparam int LEN_W  = 7;
    localparam int CNT_W  = 11;
    localparam int IDX_W  = 10;
    localparam int SQ_W   = 2 * ELEM_W;
    localparam int SUM_W  = 38;

    // Depth of the job queue between the front and back parts.
    localparam int JOBQ_DEPTH = 4;

    // Configuration register indexes.
    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_LENGTH    = 1'b1;

    // Input opcodes.
    localparam logic OP_PUSH  = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // Reset values of the configuration registers.
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(1024);
    localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(24);

    // Saturation limit of the distinct count.
    localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

    // Kind of a job handed from the front part to the back part.
    typedef struct packed {
        logic clear;
        logic full;
    } job_ctl_t;

endpackage

`default_nettype wire

>>> hdl/ndvc_store.sv
`default_nettype none

module ndvc_store #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_WIDTH   = 64
) (
    clk,
    wr_en,
    wr_addr,
    wr_data,
    rd_addr_a,
    rd_addr_b,
    rd_data_a,
    rd_data_b
);
    import ndvc_pkg::*;

    localparam int SW    = $clog2(MAX_ENTRIES);
    localparam int PW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int AW    = SW + PW;
    localparam int DEPTH = MAX_ENTRIES * (2 ** PW);

    input  wire logic              clk;
    input  wire logic              wr_en;
    input  wire logic [AW-1:0]     wr_addr;
    input  wire logic [ELEM_W-1:0] wr_data;
    input  wire logic [AW-1:0]     rd_addr_a;
    input  wire logic [AW-1:0]     rd_addr_b;
    output      logic [ELEM_W-1:0] rd_data_a;
    output      logic [ELEM_W-1:0] rd_data_b;

    logic [ELEM_W-1:0] mem [DEPTH];

    // One write port for the front part.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Two registered read ports for the scan.
    always_ff @(posedge clk)
    begin
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

`default_nettype wire

>>> hdl/ndvc_front.sv
`default_nettype none

module ndvc_front #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_WIDTH   = 64
) (
    clk,
    rst_n,
    push,
    full,
    opcode,
    element_value,
    len,
    q_full,
    q_empty,
    back_idle,
    job_push,
    job_ctl,
    job_slot,
    wr_en,
    wr_addr,
    wr_data
);
    import ndvc_pkg::*;

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    input  wire logic                      clk;
    input  wire logic                      rst_n;
    input  wire logic                      push;
    output      logic                      full;
    input  wire logic                      opcode;
    input  wire logic [ndvc_pkg::ELEM_W-1:0] element_value;
    input  wire logic [ndvc_pkg::LEN_W-1:0]  len;
    input  wire logic                      q_full;
    input  wire logic                      q_empty;
    input  wire logic                      back_idle;
    output      logic                      job_push;
    output      ndvc_pkg::job_ctl_t        job_ctl;
    output      logic [SW-1:0]             job_slot;
    output      logic                      wr_en;
    output      logic [SW+PW-1:0]          wr_addr;
    output      logic [ndvc_pkg::ELEM_W-1:0] wr_data;

    logic [PW-1:0] pos_reg;
    logic [PW-1:0] pos_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          hold_reg;
    logic          hold_next;
    logic          accept;
    logic          is_clear;
    logic          store_full;
    logic          last;

    // Input transfer; a clear holds the input until the back part has drained.
    assign full       = q_full | hold_reg;
    assign accept     = push & ~full;
    assign is_clear   = (opcode == OP_CLEAR);
    assign store_full = (count_reg >= CW'(MAX_ENTRIES));
    assign last       = ((LEN_W + 1)'(pos_reg) + (LEN_W + 1)'(1)) >= {1'b0, len};

    // Element write into the next free slot.
    assign wr_en   = accept & ~is_clear & ~store_full;
    assign wr_addr = {count_reg[SW-1:0], pos_reg};
    assign wr_data = element_value;

    // A clear or a completed vector becomes a job for the back part.
    assign job_push      = accept & (is_clear | last);
    assign job_ctl.clear = is_clear;
    assign job_ctl.full  = store_full;
    assign job_slot      = count_reg[SW-1:0];

    // Position, slot count and clear hold.
    always_comb
    begin
        pos_next   = pos_reg;
        count_next = count_reg;
        hold_next  = hold_reg & ~(q_empty & back_idle);
        if (accept)
        begin
            if (is_clear)
            begin
                pos_next   = '0;
                count_next = '0;
                hold_next  = 1'b1;
            end
            else if (last)
            begin
                pos_next = '0;
                if (!store_full)
                begin
                    count_next = count_reg + CW'(1);
                end
            end
            else
            begin
                pos_next = pos_reg + PW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            count_reg <= '0;
            hold_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            count_reg <= count_next;
            hold_reg  <= hold_next;
        end
    end

endmodule

`default_nettype wire

>>> hdl/ndvc_job_fifo.sv
`default_nettype none

module ndvc_job_fifo #(
    parameter int W = 8
) (
    clk,
    rst_n,
    wr_en,
    wr_data,
    rd_en,
    rd_data,
    full,
    empty
);
    import ndvc_pkg::*;

    localparam int PTR_W = $clog2(JOBQ_DEPTH);

    input  wire logic         clk;
    input  wire logic         rst_n;
    input  wire logic         wr_en;
    input  wire logic [W-1:0] wr_data;
    input  wire logic         rd_en;
    output      logic [W-1:0] rd_data;
    output      logic         full;
    output      logic         empty;

    logic [W-1:0]     slots [JOBQ_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W:0]   fill_reg;
    logic             do_wr;
    logic             do_rd;

    assign full    = (fill_reg == (PTR_W + 1)'(JOBQ_DEPTH));
    assign empty   = (fill_reg == '0);
    assign do_wr   = wr_en & ~full;
    assign do_rd   = rd_en & ~empty;
    assign rd_data = slots[rd_ptr_reg];

    // Job storage.
    always_ff @(posedge clk)
    begin
        if (do_wr)
        begin
            slots[wr_ptr_reg] <= wr_data;
        end
    end

    // Pointers and fill level.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_wr)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (do_rd)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (do_wr && !do_rd)
            begin
                fill_reg <= fill_reg + (PTR_W + 1)'(1);
            end
            else if (do_rd && !do_wr)
            begin
                fill_reg <= fill_reg - (PTR_W + 1)'(1);
            end
        end
    end

endmodule

`default_nettype wire

>>> hdl/ndvc_back.sv
`default_nettype none

module ndvc_back #(
    parameter int MAX_ENTRIES = 1024,
    parameter int MAX_WIDTH   = 64
) (
    clk,
    rst_n,
    job_valid,
    job_ctl,
    job_slot,
    job_pop,
    len,
    threshold,
    rd_addr_a,
    rd_addr_b,
    rd_data_a,
    rd_data_b,
    idle,
    empty,
    pop,
    is_novel,
    distinct_count,
    entry_index,
    store_full
);
    import ndvc_pkg::*;

    localparam int SW = $clog2(MAX_ENTRIES);
    localparam int PW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SCAN   = 2'd1;
    localparam logic [1:0] ST_DRAIN  = 2'd2;
    localparam logic [1:0] ST_FINISH = 2'd3;

    input  wire logic                        clk;
    input  wire logic                        rst_n;
    input  wire logic                        job_valid;
    input  wire ndvc_pkg::job_ctl_t          job_ctl;
    input  wire logic [SW-1:0]               job_slot;
    output      logic                        job_pop;
    input  wire logic [ndvc_pkg::LEN_W-1:0]  len;
    input  wire logic [ndvc_pkg::THR_W-1:0]  threshold;
    output      logic [SW+PW-1:0]            rd_addr_a;
    output      logic [SW+PW-1:0]            rd_addr_b;
    input  wire logic [ndvc_pkg::ELEM_W-1:0] rd_data_a;
    input  wire logic [ndvc_pkg::ELEM_W-1:0] rd_data_b;
    output      logic                        idle;
    output      logic                        empty;
    input  wire logic                        pop;
    output      logic                        is_novel;
    output      logic [ndvc_pkg::CNT_W-1:0]  distinct_count;
    output      logic [ndvc_pkg::IDX_W-1:0]  entry_index;
    output      logic                        store_full;

    // Sequencer state.
    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [SW-1:0]    slot_reg;
    logic [SW-1:0]    slot_next;
    logic [SW-1:0]    cand_reg;
    logic [SW-1:0]    cand_next;
    logic [PW-1:0]    k_reg;
    logic [PW-1:0]    k_next;
    logic             matched_reg;
    logic             matched_next;
    logic [CNT_W-1:0] total_reg;
    logic [CNT_W-1:0] total_next;
    logic [CNT_W-1:0] total_bump;

    // Result register.
    logic             out_valid_reg;
    logic             out_valid_next;
    logic             out_novel_reg;
    logic             out_novel_next;
    logic [CNT_W-1:0] out_count_reg;
    logic [CNT_W-1:0] out_count_next;
    logic [IDX_W-1:0] out_index_reg;
    logic [IDX_W-1:0] out_index_next;
    logic             out_full_reg;
    logic             out_full_next;
    logic             out_free;

    // Distance pipeline.
    logic              issue;
    logic              last_k;
    logic              v1_reg, f1_reg, l1_reg;
    logic              v2_reg, f2_reg, l2_reg;
    logic              v3_reg, f3_reg, l3_reg;
    logic [ELEM_W-1:0] diff_reg;
    logic [SQ_W-1:0]   sq_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic              done_reg;
    logic              pipe_empty;
    logic              hit;

    assign idle           = (state_reg == ST_IDLE);
    assign empty          = ~out_valid_reg;
    assign is_novel       = out_novel_reg;
    assign distinct_count = out_count_reg;
    assign entry_index    = out_index_reg;
    assign store_full     = out_full_reg;
    assign out_free       = ~out_valid_reg | pop;

    // One element pair of the new vector and one earlier entry per cycle.
    assign issue     = (state_reg == ST_SCAN) & ~matched_reg;
    assign last_k    = ((LEN_W + 1)'(k_reg) + (LEN_W + 1)'(1)) >= {1'b0, len};
    assign rd_addr_a = {slot_reg, k_reg};
    assign rd_addr_b = {cand_reg, k_reg};

    assign pipe_empty = ~v1_reg & ~v2_reg & ~v3_reg & ~done_reg;
    assign hit        = done_reg & (acc_reg < {{(SUM_W - THR_W){1'b0}}, threshold});
    assign total_bump = (!matched_reg && total_reg != CNT_MAX) ? total_reg + CNT_W'(1)
                                                              : total_reg;

    // Sequencer: takes jobs, walks the earlier entries, writes the result.
    always_comb
    begin
        state_next     = state_reg;
        slot_next      = slot_reg;
        cand_next      = cand_reg;
        k_next         = k_reg;
        matched_next   = matched_reg | hit;
        total_next     = total_reg;
        job_pop        = 1'b0;
        out_valid_next = out_valid_reg & ~pop;
        out_novel_next = out_novel_reg;
        out_count_next = out_count_reg;
        out_index_next = out_index_reg;
        out_full_next  = out_full_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (job_valid)
                begin
                    if (job_ctl.clear)
                    begin
                        total_next = '0;
                        job_pop    = 1'b1;
                    end
                    else if (job_ctl.full)
                    begin
                        if (out_free)
                        begin
                            job_pop        = 1'b1;
                            out_valid_next = 1'b1;
                            out_novel_next = 1'b0;
                            out_count_next = total_reg;
                            out_index_next = '0;
                            out_full_next  = 1'b1;
                        end
                    end
                    else
                    begin
                        job_pop      = 1'b1;
                        slot_next    = job_slot;
                        cand_next    = '0;
                        k_next       = '0;
                        matched_next = 1'b0;
                        state_next   = (job_slot == '0) ? ST_DRAIN : ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (matched_reg)
                begin
                    state_next = ST_DRAIN;
                end
                else if (last_k)
                begin
                    k_next = '0;
                    if (cand_reg == slot_reg - SW'(1))
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        cand_next = cand_reg + SW'(1);
                    end
                end
                else
                begin
                    k_next = k_reg + PW'(1);
                end
            end
            ST_DRAIN:
            begin
                if (pipe_empty)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    total_next     = total_bump;
                    out_valid_next = 1'b1;
                    out_novel_next = ~matched_reg;
                    out_count_next = total_bump;
                    out_index_next = IDX_W'(slot_reg);
                    out_full_next  = 1'b0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            matched_reg   <= 1'b0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            matched_reg   <= matched_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot_reg      <= slot_next;
        cand_reg      <= cand_next;
        k_reg         <= k_next;
        out_novel_reg <= out_novel_next;
        out_count_reg <= out_count_next;
        out_index_reg <= out_index_next;
        out_full_reg  <= out_full_next;
    end

    // Pipeline valid and tag bits: read, difference, square, accumulate.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg   <= 1'b0;
            v2_reg   <= 1'b0;
            v3_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            v1_reg   <= issue;
            v2_reg   <= v1_reg;
            v3_reg   <= v2_reg;
            done_reg <= v3_reg & l3_reg;
        end
    end

    // Pipeline data.
    always_ff @(posedge clk)
    begin
        f1_reg   <= (k_reg == '0);
        l1_reg   <= last_k;
        f2_reg   <= f1_reg;
        l2_reg   <= l1_reg;
        diff_reg <= (rd_data_a >= rd_data_b) ? rd_data_a - rd_data_b
                                             : rd_data_b - rd_data_a;
        f3_reg   <= f2_reg;
        l3_reg   <= l2_reg;
        sq_reg   <= SQ_W'(diff_reg) * SQ_W'(diff_reg);
        if (v3_reg)
        begin
            acc_reg <= (f3_reg ? '0 : acc_reg) + SUM_W'(sq_reg);
        end
    end

endmodule

`default_nettype wire

>>> hdl/near_duplicate_vector_counter.sv
`default_nettype none

// Near-duplicate vector counter. Vectors arrive one element per input
// transfer (opcode push); a clear opcode empties the store and the counts.
// The front part takes one element per cycle while full is low and writes
// it straight into the next free slot of the on-chip store. The element that
// completes a vector queues a job (up to four wait) and the back part then
// compares the new vector with every earlier slot, reading one element pair
// per cycle from the two store read ports: a vector stored in slot s takes
// s * vector_length element pairs, fewer when a match ends the scan early,
// and then waits for the pipeline to drain. One result per completed vector
// appears in order on the output queue. After a clear, full stays high
// until the back part has finished all earlier jobs. cfg_ready is always
// high; write configuration only while the block is idle.
module near_duplicate_vector_counter #(
    parameter int MAX_ENTRIES = ndvc_pkg::MAX_ENTRIES_DEF,
    parameter int MAX_WIDTH   = ndvc_pkg::MAX_WIDTH_DEF
) (
    clk,
    rst_n,
    push,
    full,
    opcode,
    element_value,
    empty,
    pop,
    is_novel,
    distinct_count,
    entry_index,
    store_full,
    cfg_valid,
    cfg_ready,
    cfg_index,
    cfg_data
);
    import ndvc_pkg::*;

    localparam int SW    = $clog2(MAX_ENTRIES);
    localparam int PW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
    localparam int JOB_W = $bits(job_ctl_t) + SW;

    input  wire logic                        clk;
    input  wire logic                        rst_n;
    input  wire logic                        push;
    output      logic                        full;
    input  wire logic                        opcode;
    input  wire logic [ndvc_pkg::ELEM_W-1:0] element_value;
    output      logic                        empty;
    input  wire logic                        pop;
    output      logic                        is_novel;
    output      logic [ndvc_pkg::CNT_W-1:0]  distinct_count;
    output      logic [ndvc_pkg::IDX_W-1:0]  entry_index;
    output      logic                        store_full;
    input  wire logic                        cfg_valid;
    output      logic                        cfg_ready;
    input  wire logic                        cfg_index;
    input  wire logic [ndvc_pkg::THR_W-1:0]  cfg_data;

    logic [THR_W-1:0]  thr_reg;
    logic [LEN_W-1:0]  vlen_reg;
    logic [LEN_W-1:0]  len_act;

    logic              q_full;
    logic              q_empty;
    logic              q_pop;
    logic              job_push;
    job_ctl_t          fr_ctl;
    logic [SW-1:0]     fr_slot;
    job_ctl_t          bk_ctl;
    logic [SW-1:0]     bk_slot;
    logic              back_idle;

    logic              wr_en;
    logic [SW+PW-1:0]  wr_addr;
    logic [ELEM_W-1:0] wr_data;
    logic [SW+PW-1:0]  rd_addr_a;
    logic [SW+PW-1:0]  rd_addr_b;
    logic [ELEM_W-1:0] rd_data_a;
    logic [ELEM_W-1:0] rd_data_b;

    // Configuration registers.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg  <= THR_RESET;
            vlen_reg <= LEN_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_THRESHOLD: thr_reg  <= cfg_data;
                CFG_LENGTH:    vlen_reg <= cfg_data[LEN_W-1:0];
                default:       thr_reg  <= thr_reg;
            endcase
        end
    end

    // Length in use: zero acts as one, anything above the store width as the width.
    always_comb
    begin
        if (vlen_reg == '0)
        begin
            len_act = LEN_W'(1);
        end
        else if (vlen_reg > LEN_W'(MAX_WIDTH))
        begin
            len_act = LEN_W'(MAX_WIDTH);
        end
        else
        begin
            len_act = vlen_reg;
        end
    end

    ndvc_store #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_addr_a (rd_addr_a),
        .rd_addr_b (rd_addr_b),
        .rd_data_a (rd_data_a),
        .rd_data_b (rd_data_b)
    );

    ndvc_front #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (push),
        .full          (full),
        .opcode        (opcode),
        .element_value (element_value),
        .len           (len_act),
        .q_full        (q_full),
        .q_empty       (q_empty),
        .back_idle     (back_idle),
        .job_push      (job_push),
        .job_ctl       (fr_ctl),
        .job_slot      (fr_slot),
        .wr_en         (wr_en),
        .wr_addr       (wr_addr),
        .wr_data       (wr_data)
    );

    ndvc_job_fifo #(
        .W (JOB_W)
    ) u_jobq (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_data ({fr_ctl, fr_slot}),
        .rd_en   (q_pop),
        .rd_data ({bk_ctl, bk_slot}),
        .full    (q_full),
        .empty   (q_empty)
    );

    ndvc_back #(
        .MAX_ENTRIES (MAX_ENTRIES),
        .MAX_WIDTH   (MAX_WIDTH)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .job_valid      (~q_empty),
        .job_ctl        (bk_ctl),
        .job_slot       (bk_slot),
        .job_pop        (q_pop),
        .len            (len_act),
        .threshold      (thr_reg),
        .rd_addr_a      (rd_addr_a),
        .rd_addr_b      (rd_addr_b),
        .rd_data_a      (rd_data_a),
        .rd_data_b      (rd_data_b),
        .idle           (back_idle),
        .empty          (empty),
        .pop            (pop),
        .is_novel       (is_novel),
        .distinct_count (distinct_count),
        .entry_index    (entry_index),
        .store_full     (store_full)
    );

endmodule

`default_nettype wire

>>> hdl/ndvc_checker.sv
`default_nettype none

`include "near_duplicate_vector_counter_assert.svh"

module ndvc_checker (
    clk,
    rst_n,
    empty,
    pop,
    is_novel,
    distinct_count,
    entry_index,
    store_full
);
    input wire logic        clk;
    input wire logic        rst_n;
    input wire logic        empty;
    input wire logic        pop;
    input wire logic        is_novel;
    input wire logic [10:0] distinct_count;
    input wire logic [9:0]  entry_index;
    input wire logic        store_full;

    // The result queue is empty while reset is held.
    `NDVC_ASSERT_ALWAYS(a_reset_empty, clk, !rst_n |-> empty, "result waiting during reset")

    // A waiting result that is not taken stays and keeps its novelty flag.
    `NDVC_ASSERT(a_hold, clk, rst_n, (!empty && !pop) |=> (!empty && $stable(is_novel)), "result dropped or changed while stalled")

    // A vector that found no room is never novel and names slot zero.
    `NDVC_ASSERT(a_full_shape, clk, rst_n, (!empty && store_full) |-> (!is_novel && entry_index == 10'd0), "bad store-full result")

    // A novel vector has been counted.
    `NDVC_ASSERT(a_novel_count, clk, rst_n, (!empty && is_novel) |-> (distinct_count != 11'd0), "novel result with zero count")

endmodule

bind near_duplicate_vector_counter ndvc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .empty          (empty),
    .pop            (pop),
    .is_novel       (is_novel),
    .distinct_count (distinct_count),
    .entry_index    (entry_index),
    .store_full     (store_full)
);

`default_nettype wire

>>> verif/tb_top.sv
`default_nettype none

// Testbench for the near-duplicate vector counter. Each accepted element or
// clear is run through a local model of the vector store, and every
// completed vector queues the result the block should produce. Results are
// checked in order as they are popped. Both sides stall at random.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import ndvc_pkg::*;

    localparam int MAX_ENTRIES   = MAX_ENTRIES_DEF;
    localparam int MAX_WIDTH     = MAX_WIDTH_DEF;
    localparam int RANDOM_ITEMS  = 580;
    localparam int SETTLE_CYCLES = 16;
    localparam int CYCLE_LIMIT   = 2_000_000;

    localparam logic [THR_W-1:0]  THR_MAX  = {THR_W{1'b1}};
    localparam logic [ELEM_W-1:0] ELEM_MAX = {ELEM_W{1'b1}};
    localparam logic [ELEM_W-1:0] ELEM_ONE = 16'h8000;

    // One result of a completed vector.
    typedef struct packed {
        logic             is_novel;
        logic [CNT_W-1:0] count;
        logic [IDX_W-1:0] index;
        logic             store_full;
    } vec_result_t;

    logic              clk;
    logic              rst_n;
    logic              push;
    logic              full;
    logic              opcode;
    logic [ELEM_W-1:0] element_value;
    logic              empty;
    logic              pop;
    logic              is_novel;
    logic [CNT_W-1:0]  distinct_count;
    logic [IDX_W-1:0]  entry_index;
    logic              store_full;
    logic              cfg_valid;
    logic              cfg_ready;
    logic              cfg_index;
    logic [THR_W-1:0]  cfg_data;

    // Local copy of the vector store, the counts and the settings.
    logic [ELEM_W-1:0] elem_store [MAX_ENTRIES*MAX_WIDTH];
    int unsigned       slots_used;
    int unsigned       novel_seen;
    int unsigned       elem_pos;
    logic [THR_W-1:0]  thr_setting;
    logic [LEN_W-1:0]  len_setting;

    vec_result_t       pending_results[$];
    logic [ELEM_W-1:0] vec_buf [MAX_WIDTH];
    int                err_count;
    int unsigned       items_sent;
    bit                calm;

    near_duplicate_vector_counter dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .full           (full),
        .opcode         (opcode),
        .element_value  (element_value),
        .empty          (empty),
        .pop            (pop),
        .is_novel       (is_novel),
        .distinct_count (distinct_count),
        .entry_index    (entry_index),
        .store_full     (store_full),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Out-of-range lengths are pinned to 1 and to the widest vector.
    function automatic int unsigned clamp_len(input int unsigned len);
        if (len < 1)
            return 1;
        if (len > MAX_WIDTH)
            return MAX_WIDTH;
        return len;
    endfunction

    // Element values lean toward the extremes now and then.
    function automatic logic [ELEM_W-1:0] rand_element();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return ELEM_MAX;
        if (r < 25)
            return ELEM_ONE;
        return ELEM_W'($urandom_range(0, 65535));
    endfunction

    // Idle length: mostly short, a few long, none during a calm stretch.
    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Update the local store for one accepted item and queue its result.
    task automatic predict_item(input logic op, input logic [ELEM_W-1:0] val);
        int unsigned       len;
        bit                at_cap;
        bit                is_new;
        logic [SUM_W-1:0]  dist_sq;
        logic [ELEM_W-1:0] a;
        logic [ELEM_W-1:0] b;
        logic [ELEM_W-1:0] diff;
        vec_result_t       res;
        if (op == OP_CLEAR)
        begin
            slots_used = 0;
            novel_seen = 0;
            elem_pos   = 0;
            return;
        end
        len    = clamp_len(len_setting);
        at_cap = (slots_used >= MAX_ENTRIES);
        if (!at_cap && elem_pos < MAX_WIDTH)
            elem_store[slots_used*MAX_WIDTH + elem_pos] = val;
        if (elem_pos + 1 < len)
        begin
            elem_pos++;
            return;
        end
        elem_pos = 0;

        if (at_cap)
        begin
            res.is_novel   = 1'b0;
            res.count      = CNT_W'(novel_seen);
            res.index      = '0;
            res.store_full = 1'b1;
            pending_results.push_back(res);
            return;
        end

        // Scan earlier slots until one is within the threshold.
        is_new = 1'b1;
        for (int s = 0; s < slots_used && is_new; s++)
        begin
            dist_sq = '0;
            for (int k = 0; k < len; k++)
            begin
                a       = elem_store[slots_used*MAX_WIDTH + k];
                b       = elem_store[s*MAX_WIDTH + k];
                diff    = (a >= b) ? a - b : b - a;
                dist_sq = dist_sq + SUM_W'(diff) * SUM_W'(diff);
            end
            if (dist_sq < {2'b00, thr_setting})
                is_new = 1'b0;
        end
        if (is_new && novel_seen < CNT_MAX)
            novel_seen++;

        res.is_novel   = is_new;
        res.count      = CNT_W'(novel_seen);
        res.index      = IDX_W'(slots_used);
        res.store_full = 1'b0;
        pending_results.push_back(res);
        slots_used++;
    endtask

    // Send one item after a random gap and wait for its transfer.
    task automatic send_item(input logic op, input logic [ELEM_W-1:0] val);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push          = 1'b1;
        opcode        = op;
        element_value = val;
        @(posedge clk);
        while (full)
            @(posedge clk);
        predict_item(op, val);
        items_sent++;
    endtask

    task automatic send_vector(input int unsigned n);
        for (int k = 0; k < n; k++)
            send_item(OP_PUSH, vec_buf[k]);
    endtask

    // Stop sending and let every queued result drain.
    task automatic wait_quiet();
        @(negedge clk);
        push = 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Registers are written only once the block has gone idle.
    task automatic write_reg(input logic idx, input logic [THR_W-1:0] data);
        wait_quiet();
        @(negedge clk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == CFG_THRESHOLD)
            thr_setting = data;
        else
            len_setting = data[LEN_W-1:0];
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic check_field(input string name, input longint unsigned want,
                               input longint unsigned got);
        if (want !== got)
        begin
            err_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Default settings, and the threshold compare right at its boundary.
    task automatic test_reset_values();
        vec_buf[0] = 16'd1000;
        vec_buf[1] = '0;
        vec_buf[2] = ELEM_MAX;
        vec_buf[3] = ELEM_ONE;
        vec_buf[4] = 16'hAAAA;
        vec_buf[5] = 16'h5555;
        for (int k = 6; k < 24; k++)
            vec_buf[k] = rand_element();
        send_vector(24);
        write_reg(CFG_LENGTH, THR_W'(1));
        send_item(OP_PUSH, 16'd1031);
        send_item(OP_PUSH, 16'd968);
    endtask

    // A zero threshold never matches; the largest one matches any single element.
    task automatic test_threshold_limits();
        send_item(OP_CLEAR, '0);
        write_reg(CFG_THRESHOLD, '0);
        send_item(OP_PUSH, 16'd5);
        send_item(OP_PUSH, 16'd5);
        write_reg(CFG_THRESHOLD, THR_MAX);
        send_item(OP_PUSH, '0);
        send_item(OP_PUSH, ELEM_MAX);
    endtask

    // Widest vectors: the largest distance overflows the threshold range.
    task automatic test_wide_vectors();
        send_item(OP_CLEAR, '0);
        write_reg(CFG_LENGTH, THR_W'(127));
        for (int k = 0; k < MAX_WIDTH; k++)
            vec_buf[k] = '0;
        send_vector(MAX_WIDTH);
        for (int k = 0; k < MAX_WIDTH; k++)
            vec_buf[k] = ELEM_MAX;
        send_vector(MAX_WIDTH);
        write_reg(CFG_LENGTH, THR_W'(MAX_WIDTH));
        send_vector(MAX_WIDTH);
    endtask

    // A length of zero acts as one element per vector.
    task automatic test_zero_length();
        send_item(OP_CLEAR, '0);
        write_reg(CFG_LENGTH, '0);
        write_reg(CFG_THRESHOLD, '0);
        repeat (3) send_item(OP_PUSH, rand_element());
    endtask

    // Lowering the length below the current position completes the vector.
    task automatic test_shortened_vector();
        send_item(OP_CLEAR, '0);
        write_reg(CFG_LENGTH, THR_W'(4));
        write_reg(CFG_THRESHOLD, THR_W'(1));
        send_item(OP_PUSH, 16'd10);
        send_item(OP_PUSH, 16'd20);
        send_item(OP_PUSH, 16'd30);
        send_item(OP_PUSH, 16'd40);
        send_item(OP_PUSH, 16'd10);
        send_item(OP_PUSH, 16'd20);
        send_item(OP_PUSH, 16'd30);
        write_reg(CFG_LENGTH, THR_W'(2));
        send_item(OP_PUSH, 16'd99);
        send_item(OP_PUSH, 16'd11);
        send_item(OP_PUSH, 16'd20);
    endtask

    // A clear drops a partial vector and the counts; a clear on an empty store.
    task automatic test_clear_partial();
        send_item(OP_CLEAR, '0);
        write_reg(CFG_LENGTH, THR_W'(3));
        send_item(OP_PUSH, 16'd7);
        send_item(OP_PUSH, 16'd8);
        send_item(OP_CLEAR, ELEM_MAX);
        send_item(OP_PUSH, 16'd7);
        send_item(OP_PUSH, 16'd8);
        send_item(OP_PUSH, 16'd9);
        send_item(OP_CLEAR, '0);
        send_item(OP_CLEAR, '0);
        send_item(OP_PUSH, 16'd7);
        send_item(OP_PUSH, 16'd8);
        send_item(OP_PUSH, 16'd9);
    endtask

    // Fill every slot with random elements that all match the first one under the
    // largest threshold so scans stop early, then overflow the store with short and longer vectors.
    task automatic test_store_full();
        send_item(OP_CLEAR, '0);
        write_reg(CFG_LENGTH, THR_W'(1));
        write_reg(CFG_THRESHOLD, THR_MAX);
        repeat (MAX_ENTRIES + 3) send_item(OP_PUSH, rand_element());
        write_reg(CFG_LENGTH, THR_W'(3));
        repeat (3) send_item(OP_PUSH, rand_element());
        send_item(OP_CLEAR, '0);
        repeat (3) send_item(OP_PUSH, rand_element());
    endtask

    // Phases of random settings with fresh vectors, near copies of stored
    // vectors, exact copies, stray clears and vectors left unfinished.
    task automatic test_random_traffic();
        int unsigned      first_item;
        int unsigned      new_len;
        int unsigned      n_vec;
        int unsigned      src;
        int unsigned      spread;
        int unsigned      len;
        int               r;
        int               val;
        logic [THR_W-1:0] thr;
        first_item = items_sent;
        while (items_sent - first_item < RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (r < 70)
                new_len = $urandom_range(1, 6);
            else if (r < 85)
                new_len = $urandom_range(7, 16);
            else if (r < 90)
                new_len = 0;
            else if (r < 95)
                new_len = $urandom_range(65, 127);
            else
                new_len = $urandom_range(17, 64);

            r = $urandom_range(0, 99);
            if (r < 15)
                thr = '0;
            else if (r < 25)
                thr = THR_MAX;
            else if (r < 40)
                thr = THR_W'({$urandom(), $urandom()});
            else
                thr = THR_W'($urandom_range(1, 4096));

            // A longer vector needs a fresh store so no unwritten element is compared.
            if (clamp_len(new_len) > clamp_len(len_setting) || slots_used >= 20 ||
                $urandom_range(0, 3) == 0)
                send_item(OP_CLEAR, rand_element());
            write_reg(CFG_LENGTH, THR_W'(new_len));
            write_reg(CFG_THRESHOLD, thr);

            len   = clamp_len(len_setting);
            n_vec = (len > 16) ? $urandom_range(1, 3) : $urandom_range(1, 10);
            repeat (n_vec)
            begin
                r      = $urandom_range(0, 99);
                src    = (slots_used > 0) ? $urandom_range(0, slots_used - 1) : 0;
                spread = $urandom_range(0, 24);
                for (int k = 0; k < len; k++)
                begin
                    if (r < 40 || slots_used == 0 || slots_used >= MAX_ENTRIES)
                        vec_buf[k] = rand_element();
                    else
                    begin
                        val = int'(elem_store[src*MAX_WIDTH + k]);
                        if (r < 85)
                            val = val + int'($urandom_range(0, 2 * spread)) - int'(spread);
                        if (val < 0)
                            val = 0;
                        if (val > 65535)
                            val = 65535;
                        vec_buf[k] = ELEM_W'(val);
                    end
                end
                for (int k = 0; k < len; k++)
                begin
                    if ($urandom_range(0, 99) == 0)
                        send_item(OP_CLEAR, rand_element());
                    send_item(OP_PUSH, vec_buf[k]);
                end
            end

            // Sometimes leave a vector half done across the next settings.
            if (len > 1 && $urandom_range(0, 4) == 0)
                repeat ($urandom_range(1, len - 1)) send_item(OP_PUSH, rand_element());
        end
    endtask

    // Calm stretches with no idling on either side.
    initial
    begin
        calm = 1'b0;
        forever
        begin
            repeat ($urandom_range(150, 600)) @(posedge clk);
            calm = 1'b1;
            repeat ($urandom_range(40, 200)) @(posedge clk);
            calm = 1'b0;
        end
    end

    // Result side: random stalls on pop.
    initial
    begin : pop_driver
        int stall_left;
        pop        = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (calm || stall_left == 0)
            begin
                pop = 1'b1;
                if (!calm)
                    stall_left = pick_gap();
            end
            else
            begin
                pop = 1'b0;
                stall_left--;
            end
        end
    end

    // Compare each result transfer with the oldest expected result.
    always @(posedge clk)
    begin : result_check
        vec_result_t want;
        if (rst_n && pop && !empty)
        begin
            if (pending_results.size() == 0)
            begin
                err_count++;
                $display("%0t: unexpected result, expected none, actual novel %0b count %0d index %0d full %0b",
                         $time, is_novel, distinct_count, entry_index, store_full);
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("is_novel", want.is_novel, is_novel);
                check_field("distinct_count", want.count, distinct_count);
                check_field("entry_index", want.index, entry_index);
                check_field("store_full", want.store_full, store_full);
            end
        end
    end

    initial
    begin : watchdog
        int cycles;
        for (cycles = 0; cycles < CYCLE_LIMIT; cycles++)
            @(posedge clk);
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin : main
        rst_n         = 1'b0;
        push          = 1'b0;
        opcode        = OP_PUSH;
        element_value = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_THRESHOLD;
        cfg_data      = '0;
        thr_setting   = THR_RESET;
        len_setting   = LEN_RESET;
        slots_used    = 0;
        novel_seen    = 0;
        elem_pos      = 0;
        err_count     = 0;
        items_sent    = 0;
        for (int i = 0; i < MAX_ENTRIES*MAX_WIDTH; i++)
            elem_store[i] = '0;
        for (int k = 0; k < MAX_WIDTH; k++)
            vec_buf[k] = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_reset_values();
        test_threshold_limits();
        test_wide_vectors();
        test_zero_length();
        test_shortened_vector();
        test_clear_partial();
        test_store_full();
        test_random_traffic();

        // Drain, then watch a while longer for stray results.
        wait_quiet();
        repeat (64) @(posedge clk);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
